[src/imhaq_pkg.sv]
// shared types and constants of the indexed max-heap affinity queue
package imhaq_pkg;

  localparam int unsigned ROWS      = 1024;
  localparam int unsigned IDX_W     = $clog2(ROWS);
  localparam int unsigned CNT_W     = IDX_W + 1;
  localparam int unsigned AFF_W     = 16;
  localparam int unsigned ROW_CNT_W = 11;

  typedef enum logic [1:0] {
    OP_INIT = 2'd0,
    OP_INC  = 2'd1,
    OP_DEC  = 2'd2,
    OP_POP  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_NOTQ  = 2'd2,
    ST_SAT   = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_START,
    CMD_INIT_WR,
    CMD_INIT_END,
    CMD_RD_MAP,
    CMD_RD_SLOT,
    CMD_LOAD_ITEM,
    CMD_RD_ROOT,
    CMD_POP_TAKE,
    CMD_POP_LOAD,
    CMD_RD_PARENT,
    CMD_RD_LEFT,
    CMD_RD_RIGHT,
    CMD_WR_ITEM,
    CMD_WR_UP,
    CMD_WR_DOWN,
    CMD_FINISH
  } dp_cmd_e;

  typedef struct packed {
    dp_cmd_e code;
    logic    st_we;
    status_e st;
  } dp_cmd_t;

  typedef struct packed {
    op_e  op;
    logic clr_done;
    logic init_done;
    logic hit;
    logic sat;
    logic cnt_zero;
    logic s_zero;
    logic leaf;
    logic up_go;
    logic down_go;
  } dp_sts_t;

endpackage

[src/imhaq_ctrl.sv]
// sequencer of the heap operations
module imhaq_ctrl import imhaq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_INIT, S_RDSLOT, S_CHECK, S_POPTAKE, S_POPLOAD,
    S_UP, S_UPCMP, S_DOWN, S_DNR, S_DNCMP, S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '{code: CMD_NONE, st_we: 1'b0, st: ST_OK};
    unique case (state_q)
      S_CLEAR: begin
        // preset every row-to-slot map entry once after reset
        if (sts_i.clr_done) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.code = CMD_CLEAR;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.code = CMD_START;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts_i.op)
          OP_INIT: state_d = S_INIT;
          OP_INC, OP_DEC: begin
            cmd_o.code = CMD_RD_MAP;
            state_d    = S_RDSLOT;
          end
          OP_POP: begin
            if (sts_i.cnt_zero) begin
              cmd_o.st_we = 1'b1;
              cmd_o.st    = ST_EMPTY;
              state_d     = S_FIN;
            end else begin
              cmd_o.code = CMD_RD_ROOT;
              state_d    = S_POPTAKE;
            end
          end
          default: state_d = S_FIN;
        endcase
      end
      S_INIT: begin
        if (sts_i.init_done) begin
          cmd_o.code = CMD_INIT_END;
          state_d    = S_FIN;
        end else begin
          cmd_o.code = CMD_INIT_WR;
        end
      end
      S_RDSLOT: begin
        cmd_o.code = CMD_RD_SLOT;
        state_d    = S_CHECK;
      end
      S_CHECK: begin
        priority if (!sts_i.hit) begin
          cmd_o.st_we = 1'b1;
          cmd_o.st    = ST_NOTQ;
          state_d     = S_FIN;
        end else if (sts_i.sat) begin
          cmd_o.st_we = 1'b1;
          cmd_o.st    = ST_SAT;
          state_d     = S_FIN;
        end else begin
          cmd_o.code = CMD_LOAD_ITEM;
          state_d    = (sts_i.op == OP_INC) ? S_UP : S_DOWN;
        end
      end
      S_POPTAKE: begin
        cmd_o.code = CMD_POP_TAKE;
        state_d    = S_POPLOAD;
      end
      S_POPLOAD: begin
        if (sts_i.cnt_zero) begin
          state_d = S_FIN;
        end else begin
          cmd_o.code = CMD_POP_LOAD;
          state_d    = S_DOWN;
        end
      end
      S_UP: begin
        if (sts_i.s_zero) begin
          cmd_o.code = CMD_WR_ITEM;
          state_d    = S_FIN;
        end else begin
          cmd_o.code = CMD_RD_PARENT;
          state_d    = S_UPCMP;
        end
      end
      S_UPCMP: begin
        if (sts_i.up_go) begin
          cmd_o.code = CMD_WR_UP;
          state_d    = S_UP;
        end else begin
          cmd_o.code = CMD_WR_ITEM;
          state_d    = S_FIN;
        end
      end
      S_DOWN: begin
        if (sts_i.leaf) begin
          cmd_o.code = CMD_WR_ITEM;
          state_d    = S_FIN;
        end else begin
          cmd_o.code = CMD_RD_LEFT;
          state_d    = S_DNR;
        end
      end
      S_DNR: begin
        cmd_o.code = CMD_RD_RIGHT;
        state_d    = S_DNCMP;
      end
      S_DNCMP: begin
        if (sts_i.down_go) begin
          cmd_o.code = CMD_WR_DOWN;
          state_d    = S_DOWN;
        end else begin
          cmd_o.code = CMD_WR_ITEM;
          state_d    = S_FIN;
        end
      end
      S_FIN: begin
        // wait until the output word register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.code  = CMD_FINISH;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[src/imhaq_dp.sv]
// heap memories, slot registers and result registers
module imhaq_dp import imhaq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  input  logic [1:0]           opcode_i,
  input  logic [IDX_W-1:0]     row_i,
  input  logic [ROW_CNT_W-1:0] row_count_i,
  output dp_sts_t              sts_o,
  output logic [IDX_W-1:0]     popped_row_o,
  output logic [AFF_W-1:0]     popped_affinity_o,
  output logic [CNT_W-1:0]     queue_size_o,
  output logic [1:0]           status_o
);

  localparam logic [AFF_W-1:0] AFF_MAX = '1;

  logic [IDX_W-1:0] row_mem [ROWS];
  logic [AFF_W-1:0] aff_mem [ROWS];
  logic [IDX_W-1:0] map_mem [ROWS];

  op_e              op_q;
  status_e          st_q, o_st_q;
  logic [IDX_W-1:0] row_q, s_q, it_row_q, l_row_q, rd_row_q, rd_map_q, pop_row_q, o_row_q;
  logic [AFF_W-1:0] it_aff_q, l_aff_q, rd_aff_q, pop_aff_q, o_aff_q;
  logic [CNT_W-1:0] count_q, i_q, tgt_q, o_cnt_q, clr_q;

  logic [CNT_W-1:0] left_w, right_w, n_w;
  logic [IDX_W-1:0] parent_w, c_slot_w, c_row_w;
  logic [AFF_W-1:0] c_aff_w;
  logic             take_left_w;
  logic [IDX_W-1:0] raddr_w, waddr_w, wrow_w;
  logic [AFF_W-1:0] waff_w;
  logic             we_w;

  assign left_w   = {s_q, 1'b1};
  assign right_w  = left_w + CNT_W'(1);
  assign parent_w = IDX_W'((s_q - IDX_W'(1)) >> 1);

  // ties between children go right
  assign take_left_w = (right_w >= count_q) || (l_aff_q > rd_aff_q);
  assign c_slot_w    = take_left_w ? left_w[IDX_W-1:0] : right_w[IDX_W-1:0];
  assign c_row_w     = take_left_w ? l_row_q : rd_row_q;
  assign c_aff_w     = take_left_w ? l_aff_q : rd_aff_q;

  assign n_w = (row_count_i > CNT_W'(ROWS)) ? CNT_W'(ROWS) : CNT_W'(row_count_i);

  always_comb begin
    unique case (cmd_i.code)
      CMD_RD_SLOT:   raddr_w = rd_map_q;
      CMD_RD_ROOT:   raddr_w = '0;
      CMD_POP_TAKE:  raddr_w = IDX_W'(count_q - CNT_W'(1));
      CMD_RD_PARENT: raddr_w = parent_w;
      CMD_RD_LEFT:   raddr_w = left_w[IDX_W-1:0];
      CMD_RD_RIGHT:  raddr_w = right_w[IDX_W-1:0];
      default:       raddr_w = s_q;
    endcase
  end

  always_comb begin
    we_w    = 1'b1;
    waddr_w = s_q;
    wrow_w  = it_row_q;
    waff_w  = it_aff_q;
    unique case (cmd_i.code)
      CMD_CLEAR: begin
        // map entry of row clr_q points at slot 0
        waddr_w = '0;
        wrow_w  = clr_q[IDX_W-1:0];
        waff_w  = '0;
      end
      CMD_INIT_WR: begin
        waddr_w = i_q[IDX_W-1:0];
        wrow_w  = i_q[IDX_W-1:0] + IDX_W'(1);
        waff_w  = '0;
      end
      CMD_WR_ITEM: ;
      CMD_WR_UP: begin
        wrow_w = rd_row_q;
        waff_w = rd_aff_q;
      end
      CMD_WR_DOWN: begin
        wrow_w = c_row_w;
        waff_w = c_aff_w;
      end
      default: we_w = 1'b0;
    endcase
  end

  // heap slots and row-to-slot map share one write strobe
  always_ff @(posedge clk_i) begin
    if (we_w) begin
      row_mem[waddr_w] <= wrow_w;
      aff_mem[waddr_w] <= waff_w;
      map_mem[wrow_w]  <= waddr_w;
    end
    rd_row_q <= row_mem[raddr_w];
    rd_aff_q <= aff_mem[raddr_w];
    rd_map_q <= map_mem[row_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      op_q    <= OP_INIT;
      st_q    <= ST_OK;
      clr_q   <= '0;
    end else begin
      if (cmd_i.st_we) begin
        st_q <= cmd_i.st;
      end
      unique case (cmd_i.code)
        CMD_CLEAR: clr_q <= clr_q + CNT_W'(1);
        CMD_START: begin
          op_q  <= op_e'(opcode_i);
          st_q  <= ST_OK;
        end
        CMD_INIT_END: count_q <= tgt_q;
        CMD_POP_TAKE: count_q <= count_q - CNT_W'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.code)
      CMD_START: begin
        row_q     <= row_i;
        i_q       <= '0;
        tgt_q     <= (n_w > CNT_W'(1)) ? n_w - CNT_W'(1) : '0;
        pop_row_q <= '0;
        pop_aff_q <= '0;
      end
      CMD_INIT_WR: i_q <= i_q + CNT_W'(1);
      CMD_RD_SLOT: s_q <= rd_map_q;
      CMD_LOAD_ITEM: begin
        it_row_q <= row_q;
        it_aff_q <= (op_q == OP_INC) ? rd_aff_q + AFF_W'(1) : rd_aff_q - AFF_W'(1);
      end
      CMD_POP_TAKE: begin
        pop_row_q <= rd_row_q;
        pop_aff_q <= rd_aff_q;
        s_q       <= '0;
      end
      CMD_POP_LOAD: begin
        it_row_q <= rd_row_q;
        it_aff_q <= rd_aff_q;
      end
      CMD_RD_RIGHT: begin
        l_row_q <= rd_row_q;
        l_aff_q <= rd_aff_q;
      end
      CMD_WR_UP:   s_q <= parent_w;
      CMD_WR_DOWN: s_q <= c_slot_w;
      CMD_FINISH: begin
        o_row_q <= pop_row_q;
        o_aff_q <= pop_aff_q;
        o_cnt_q <= count_q;
        o_st_q  <= st_q;
      end
      default: ;
    endcase
  end

  // a row is queued exactly when its mapped slot is live and points back at it
  assign sts_o.op        = op_q;
  assign sts_o.clr_done  = clr_q[IDX_W];
  assign sts_o.init_done = (i_q == tgt_q);
  assign sts_o.hit       = (CNT_W'(s_q) < count_q) && (rd_row_q == row_q);
  assign sts_o.sat       = (op_q == OP_INC) ? (rd_aff_q == AFF_MAX) : (rd_aff_q == '0);
  assign sts_o.cnt_zero  = (count_q == '0);
  assign sts_o.s_zero    = (s_q == '0);
  assign sts_o.leaf      = (left_w >= count_q);
  assign sts_o.up_go     = (it_aff_q > rd_aff_q);
  assign sts_o.down_go   = (it_aff_q < c_aff_w);

  assign popped_row_o      = o_row_q;
  assign popped_affinity_o = o_aff_q;
  assign queue_size_o      = o_cnt_q;
  assign status_o          = o_st_q;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q < CNT_W'(ROWS)) else $error("heap count out of range");
  a_pop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.code == CMD_POP_TAKE) |=> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("pop did not shrink heap");
  a_wr_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.code == CMD_WR_ITEM || cmd_i.code == CMD_WR_UP || cmd_i.code == CMD_WR_DOWN)
    |-> (CNT_W'(s_q) < count_q)) else $error("write beyond live slots");
`endif

endmodule

[src/indexed_max_heap_affinity_queue.sv]
// Indexed binary max-heap of rows keyed by a 16-bit affinity. One result word
// per input word. After reset a clearing pass presets the row-to-slot map,
// and no word is taken before it ends. Init writes one heap slot per cycle;
// increment moves the item up one level per parent read, and decrement and
// pop move it down one level per pair of child reads, at most 9 levels. An
// unqueued row, a saturated affinity or a pop that empties the heap answers
// without a heap walk, and a pop on an empty heap without any memory read.
// The single read port of the heap memory sets the cost per level. A new word
// can be taken in the cycle after the previous result is loaded into the output
// register; a result that is not yet taken holds the next one back.
module indexed_max_heap_affinity_queue import imhaq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // row[9:0], zero fill
  input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // popped_row[9:0], popped_affinity[25:10],
                                     // queue_size[36:26], zero fill
  output logic [1:0]  m_axis_tuser,  // status[1:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] REG_ROW_COUNT = 2'd0;

  logic [ROW_CNT_W-1:0] row_count_q;
  dp_cmd_t              cmd;
  dp_sts_t              sts;
  logic [IDX_W-1:0]     popped_row;
  logic [AFF_W-1:0]     popped_affinity;
  logic [CNT_W-1:0]     queue_size;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= ROW_CNT_W'(ROWS);
    end else if (psel && penable && pwrite && (paddr == REG_ROW_COUNT)) begin
      row_count_q <= pwdata[ROW_CNT_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == REG_ROW_COUNT) ? {{(32-ROW_CNT_W){1'b0}}, row_count_q} : '0;

  imhaq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  imhaq_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .opcode_i          (s_axis_tuser),
    .row_i             (s_axis_tdata[IDX_W-1:0]),
    .row_count_i       (row_count_q),
    .sts_o             (sts),
    .popped_row_o      (popped_row),
    .popped_affinity_o (popped_affinity),
    .queue_size_o      (queue_size),
    .status_o          (m_axis_tuser)
  );

  assign m_axis_tdata = {3'b000, queue_size, popped_affinity, popped_row};

endmodule
